@@ hdl/sbct_pkg.sv @@
// shared types and constants for the swept box collision time block
`timescale 1ns / 1ps
package sbct_pkg;

  localparam int CoordWidth = 32;
  localparam int TimeWidth = 48;
  localparam int SizeWidth = 31;
  localparam int NumAxes = 3;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  // input beat, mover_min_x in the low bits
  typedef struct packed {
    logic signed [CoordWidth-1:0] obstacle_min_z, obstacle_min_y, obstacle_min_x;
    logic signed [CoordWidth-1:0] velocity_z, velocity_y, velocity_x;
    logic signed [CoordWidth-1:0] mover_max_z, mover_max_y, mover_max_x;
    logic signed [CoordWidth-1:0] mover_min_z, mover_min_y, mover_min_x;
  } sbct_in_t;

  // result beat, hit_time in the low bits
  typedef struct packed {
    logic [1:0]                  normal_axis;
    logic                        hit;
    logic signed [TimeWidth-1:0] hit_time;
  } sbct_out_t;

endpackage

@@ hdl/sbct_div.sv @@
// pipelined restoring divider: quotient of (gap << 16) by velocity, saturated
`timescale 1ns / 1ps
module sbct_div import sbct_pkg::*; #(
  parameter int GapWidth  = 34,
  parameter int VelWidth  = 32,
  parameter int TimeWidth = 48
) (
  input  logic                        clk_i,
  input  logic signed [GapWidth-1:0]  gap_i,
  input  logic signed [VelWidth-1:0]  vel_i,
  output logic signed [TimeWidth-1:0] time_o
);
  localparam int NumW = GapWidth + 16;
  localparam int VW   = VelWidth;
  localparam int RemW = VW + 1;
  localparam int QLim = (NumW < TimeWidth + 1) ? NumW : TimeWidth + 1;

  logic [NumW-1:0] num_q   [NumW+1];
  logic [VW-1:0]   den_q   [NumW+1];
  logic [RemW-1:0] rem_q   [NumW+1];
  logic [NumW-1:0] quo_q   [NumW+1];
  logic            neg_q   [NumW+1];

  logic [GapWidth-1:0] gmag;
  logic [VW-1:0]       vmag;

  always_comb begin
    gmag = gap_i[GapWidth-1] ? GapWidth'(-gap_i) : GapWidth'(gap_i);
    vmag = vel_i[VW-1] ? VW'(-vel_i) : VW'(vel_i);
  end

  always_ff @(posedge clk_i) begin
    num_q[0] <= {gmag, 16'd0};
    den_q[0] <= vmag;
    rem_q[0] <= '0;
    quo_q[0] <= '0;
    neg_q[0] <= gap_i[GapWidth-1] ^ vel_i[VW-1];
  end

  for (genvar s = 0; s < NumW; s++) begin : g_step
    logic [RemW-1:0] sh;
    logic [RemW:0]   diff;
    always_comb begin
      sh   = {rem_q[s][RemW-2:0], num_q[s][NumW-1-s]};
      diff = {1'b0, sh} - {2'b0, den_q[s]};
    end
    always_ff @(posedge clk_i) begin
      num_q[s+1] <= num_q[s];
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      if (!diff[RemW]) begin
        rem_q[s+1] <= diff[RemW-1:0];
        quo_q[s+1] <= quo_q[s] | (NumW'(1) << (NumW-1-s));
      end else begin
        rem_q[s+1] <= sh;
        quo_q[s+1] <= quo_q[s];
      end
    end
  end

  logic [NumW-1:0] q;
  logic            big;
  logic [TimeWidth:0] lim, mag;
  always_comb begin
    q   = quo_q[NumW];
    lim = neg_q[NumW] ? (TimeWidth+1)'(1) << (TimeWidth-1)
                      : ((TimeWidth+1)'(1) << (TimeWidth-1)) - 1'b1;
    big = 1'b0;
    for (int b = QLim; b < NumW; b++) big = big | q[b];
    mag = (TimeWidth+1)'(q[QLim-1:0]);
    if (big || mag > lim) mag = lim;
    time_o = neg_q[NumW] ? TimeWidth'(-mag) : TimeWidth'(mag);
  end
endmodule

@@ hdl/sbct_lane.sv @@
// one axis lane: gaps, entry and exit times for a single axis
`timescale 1ns / 1ps
module sbct_lane import sbct_pkg::*; #(
  parameter int CoordWidth = 32,
  parameter int TimeWidth  = 48
) (
  input  logic                         clk_i,
  input  logic signed [CoordWidth-1:0] mmin_i,
  input  logic signed [CoordWidth-1:0] mmax_i,
  input  logic signed [CoordWidth-1:0] vel_i,
  input  logic signed [CoordWidth-1:0] omin_i,
  input  logic [SizeWidth-1:0]         size_i,
  output logic signed [TimeWidth-1:0]  entry_o,
  output logic signed [TimeWidth-1:0]  exit_o
);
  localparam int OW = (CoordWidth > SizeWidth ? CoordWidth : SizeWidth) + 2;
  localparam int GW = OW + 1;
  localparam int Lat = GW + 16 + 1;
  localparam logic signed [TimeWidth-1:0] TMax = {1'b0, {(TimeWidth-1){1'b1}}};
  localparam logic signed [TimeWidth-1:0] TMin = {1'b1, {(TimeWidth-1){1'b0}}};
  localparam logic signed [64:0] FarRaw = -65'sd65536000000;
  localparam logic signed [TimeWidth-1:0] Far =
    (FarRaw < 65'(signed'(TMin))) ? TMin : TimeWidth'(FarRaw);

  logic signed [OW-1:0] omax;
  logic signed [GW-1:0] eg, xg;
  logic                 pos;
  always_comb begin
    omax = OW'(omin_i) + signed'(OW'(size_i));
    pos  = !vel_i[CoordWidth-1] && (vel_i != '0);
    if (pos) begin
      eg = GW'(omin_i) - GW'(mmax_i);
      xg = GW'(omax) - GW'(mmin_i);
    end else begin
      eg = GW'(omax) - GW'(mmin_i);
      xg = GW'(omin_i) - GW'(mmax_i);
    end
  end

  logic signed [TimeWidth-1:0] en_t, ex_t;
  sbct_div #(.GapWidth(GW), .VelWidth(CoordWidth), .TimeWidth(TimeWidth)) u_en (
    .clk_i(clk_i), .gap_i(eg), .vel_i(vel_i), .time_o(en_t));
  sbct_div #(.GapWidth(GW), .VelWidth(CoordWidth), .TimeWidth(TimeWidth)) u_ex (
    .clk_i(clk_i), .gap_i(xg), .vel_i(vel_i), .time_o(ex_t));

  logic zero_q [Lat];
  always_ff @(posedge clk_i) begin
    zero_q[0] <= (vel_i == '0);
    for (int i = 1; i < Lat; i++) zero_q[i] <= zero_q[i-1];
  end

  always_comb begin
    entry_o = zero_q[Lat-1] ? TMin : en_t;
    exit_o  = zero_q[Lat-1] ? TMax : ex_t;
    if (entry_o > TimeWidth'(65536)) entry_o = Far;
  end
endmodule

@@ hdl/sbct_merge.sv @@
// merge of the three lanes: latest entry, earliest exit, hit and axis
`timescale 1ns / 1ps
module sbct_merge import sbct_pkg::*; #(
  parameter int TimeWidth = 48
) (
  input  logic                        clk_i,
  input  logic signed [TimeWidth-1:0] en_i [NumAxes],
  input  logic signed [TimeWidth-1:0] ex_i [NumAxes],
  output logic signed [TimeWidth-1:0] time_o,
  output logic                        hit_o,
  output axis_e                       axis_o
);
  logic signed [TimeWidth-1:0] ent, ext;
  logic                        hit;
  axis_e                       ax;
  always_comb begin
    ent = en_i[0];
    if (en_i[1] > ent) ent = en_i[1];
    if (en_i[2] > ent) ent = en_i[2];
    ext = ex_i[0];
    if (ex_i[1] < ext) ext = ex_i[1];
    if (ex_i[2] < ext) ext = ex_i[2];
    hit = !(ent > ext || (en_i[0] < 0 && en_i[1] < 0 && en_i[2] < 0));
    if (!hit) ax = AXIS_X;
    else if (en_i[0] > en_i[1] && en_i[0] > en_i[2]) ax = AXIS_X;
    else if (en_i[1] > en_i[0] && en_i[1] > en_i[2]) ax = AXIS_Y;
    else ax = AXIS_Z;
  end

  always_ff @(posedge clk_i) begin
    time_o <= hit ? ent : TimeWidth'(65536);
    hit_o  <= hit;
    axis_o <= ax;
  end
endmodule

@@ hdl/swept_box_collision_time.sv @@
// top level of the swept box collision time block
// usage:
//   raise start with a beat on in_i; the block is never busy, so busy
//   stays low and a new beat may enter every clock cycle.
//   three axis lanes each run two pipelined restoring dividers, one
//   quotient bit per stage; a merge stage picks latest entry and earliest
//   exit and registers the result.
//   throughput one beat per cycle, set by the fully pipelined dividers.
//   done_o is high for exactly one cycle with the beat on out_o; the
//   receiver cannot stall, so it must take every beat.
//   obstacle sizes are written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while idle; reset sets each size to 1.0 and drops all beats in flight.
//   reset: rst_ni, asynchronous, active low.
`timescale 1ns / 1ps
module swept_box_collision_time import sbct_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  sbct_in_t             in_i,
  output logic                 done_o,
  output sbct_out_t            out_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [SizeWidth-1:0] cfg_data_i
);
  localparam int OW = (CoordWidth > SizeWidth ? CoordWidth : SizeWidth) + 3;
  localparam int Lat = OW + 16 + 2;

  assign busy = 1'b0;

  logic [SizeWidth-1:0] size_q [NumAxes];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) size_q[i] <= SizeWidth'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE_X: size_q[0] <= cfg_data_i;
        CFG_SIZE_Y: size_q[1] <= cfg_data_i;
        CFG_SIZE_Z: size_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [CoordWidth-1:0] mmin [NumAxes], mmax [NumAxes];
  logic signed [CoordWidth-1:0] vel [NumAxes], omin [NumAxes];
  logic signed [TimeWidth-1:0]  en [NumAxes], ex [NumAxes];
  assign mmin = '{in_i.mover_min_x, in_i.mover_min_y, in_i.mover_min_z};
  assign mmax = '{in_i.mover_max_x, in_i.mover_max_y, in_i.mover_max_z};
  assign vel  = '{in_i.velocity_x, in_i.velocity_y, in_i.velocity_z};
  assign omin = '{in_i.obstacle_min_x, in_i.obstacle_min_y, in_i.obstacle_min_z};

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    sbct_lane #(.CoordWidth(CoordWidth), .TimeWidth(TimeWidth)) u_lane (
      .clk_i(clk_i), .mmin_i(mmin[a]), .mmax_i(mmax[a]), .vel_i(vel[a]),
      .omin_i(omin[a]), .size_i(size_q[a]), .entry_o(en[a]), .exit_o(ex[a]));
  end

  logic signed [TimeWidth-1:0] hit_time;
  logic                        hit;
  axis_e                       ax;
  sbct_merge #(.TimeWidth(TimeWidth)) u_merge (
    .clk_i(clk_i), .en_i(en), .ex_i(ex), .time_o(hit_time),
    .hit_o(hit), .axis_o(ax));
  assign out_o = {ax, hit, hit_time};

  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Lat-2:0], start && !busy};
  end
  assign done_o = vld_q[Lat-1];

  a_no_hit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit |-> hit_time == TimeWidth'(65536)
      && ax == AXIS_X) else $error("no hit beat malformed");
  a_hit_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit |-> !hit_time[TimeWidth-1])
    else $error("hit with negative time");
  a_hit_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit |-> hit_time <= TimeWidth'(65536))
    else $error("hit time beyond one");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[Lat-2])) else $error("beat without start");
endmodule

@@ bench/tb_top.sv @@
// testbench for the swept box collision time block: random and directed queries checked
`timescale 1ns / 1ps
module tb_top;
  import sbct_pkg::*;

  localparam int CW = 32;
  localparam int TW = 48;
  localparam longint TMAX = (64'sd1 <<< (TW - 1)) - 1;
  localparam longint TMIN = -TMAX - 1;
  localparam longint ONE = 65536;
  localparam longint FAR_PAST = -64'sd65536000000;

  typedef struct packed {
    logic signed [CW-1:0] min_x, min_y, min_z;
    logic signed [CW-1:0] max_x, max_y, max_z;
    logic signed [CW-1:0] vel_x, vel_y, vel_z;
    logic signed [CW-1:0] obs_x, obs_y, obs_z;
  } query_t;

  function automatic sbct_in_t to_beat(query_t q);
    sbct_in_t b;
    b.mover_min_x = q.min_x;
    b.mover_min_y = q.min_y;
    b.mover_min_z = q.min_z;
    b.mover_max_x = q.max_x;
    b.mover_max_y = q.max_y;
    b.mover_max_z = q.max_z;
    b.velocity_x = q.vel_x;
    b.velocity_y = q.vel_y;
    b.velocity_z = q.vel_z;
    b.obstacle_min_x = q.obs_x;
    b.obstacle_min_y = q.obs_y;
    b.obstacle_min_z = q.obs_z;
    return b;
  endfunction

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  query_t query = '0;
  sbct_in_t beat;
  logic done_o;
  sbct_out_t verdict;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx = CFG_SIZE_X;
  logic [SizeWidth-1:0] cfg_data_i = '0;

  assign beat = to_beat(query);

  swept_box_collision_time uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(beat),
    .done_o(done_o), .out_o(verdict), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  query_t pending_q[$];
  sbct_out_t verdict_q[$];
  logic [SizeWidth-1:0] obs_size[3];
  logic took = 1'b0;
  int gap_left = 0;
  int errors = 0;

  function automatic longint sweep_div(longint gap, longint vel);
    longint q;
    q = (gap * ONE) / vel;
    if (q > TMAX) q = TMAX;
    if (q < TMIN) q = TMIN;
    return q;
  endfunction

  function automatic sbct_out_t predict_hit(query_t q);
    longint mn[3], mx[3], v[3], om[3], en[3], ex[3];
    longint omax, eg, xg, entry, exit_t;
    sbct_out_t r;
    mn = '{q.min_x, q.min_y, q.min_z};
    mx = '{q.max_x, q.max_y, q.max_z};
    v = '{q.vel_x, q.vel_y, q.vel_z};
    om = '{q.obs_x, q.obs_y, q.obs_z};
    for (int i = 0; i < 3; i++) begin
      omax = om[i] + longint'({1'b0, obs_size[i]});
      if (v[i] > 0) begin
        eg = om[i] - mx[i];
        xg = omax - mn[i];
      end else begin
        eg = omax - mn[i];
        xg = om[i] - mx[i];
      end
      if (v[i] == 0) begin
        en[i] = TMIN;
        ex[i] = TMAX;
      end else begin
        en[i] = sweep_div(eg, v[i]);
        ex[i] = sweep_div(xg, v[i]);
      end
      if (en[i] > ONE) en[i] = FAR_PAST;
    end
    entry = en[0];
    if (en[1] > entry) entry = en[1];
    if (en[2] > entry) entry = en[2];
    exit_t = ex[0];
    if (ex[1] < exit_t) exit_t = ex[1];
    if (ex[2] < exit_t) exit_t = ex[2];
    if (entry > exit_t || (en[0] < 0 && en[1] < 0 && en[2] < 0)) begin
      r.hit_time = TW'(ONE);
      r.hit = 1'b0;
      r.normal_axis = AXIS_X;
    end else begin
      r.hit_time = TW'(entry);
      r.hit = 1'b1;
      if (en[0] > en[1] && en[0] > en[2]) r.normal_axis = AXIS_X;
      else if (en[1] > en[0] && en[1] > en[2]) r.normal_axis = AXIS_Y;
      else r.normal_axis = AXIS_Z;
    end
    return r;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!start || took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        query <= pending_q.pop_front();
        start <= 1'b1;
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sbct_out_t want;
    took <= start && !busy && rst_ni;
    if (rst_ni && start && !busy) verdict_q.push_back(predict_hit(query));
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %p", verdict);
      end else begin
        want = verdict_q.pop_front();
        if (verdict.hit_time !== want.hit_time || verdict.hit !== want.hit ||
            verdict.normal_axis !== want.normal_axis) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                     want.hit_time, want.hit, want.normal_axis,
                     verdict.hit_time, verdict.hit, verdict.normal_axis);
        end
      end
    end
  end

  function automatic logic signed [CW-1:0] near_coord();
    return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
  endfunction

  function automatic logic signed [CW-1:0] near_vel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return $urandom;
    return $signed($urandom_range(0, 16 * 65536)) - 8 * 65536;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    logic signed [CW-1:0] mn[3], sz[3], v[3], o[3];
    if ($urandom_range(0, 9) < 2) begin
      q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return q;
    end
    for (int i = 0; i < 3; i++) begin
      mn[i] = near_coord();
      sz[i] = $urandom_range(0, 2 * 65536);
      o[i] = near_coord();
      v[i] = near_vel();
    end
    q = {mn[0], mn[1], mn[2], mn[0] + sz[0], mn[1] + sz[1], mn[2] + sz[2],
         v[0], v[1], v[2], o[0], o[1], o[2]};
    return q;
  endfunction

  task automatic write_size(cfg_idx_e idx, logic [SizeWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx <= idx;
    cfg_data_i <= val;
    obs_size[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !start && verdict_q.size() == 0);
    repeat (2) @(negedge clk_i);
  endtask

  localparam logic signed [CW-1:0] SMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] SMIN = 32'sh80000000;

  initial begin
    logic [SizeWidth-1:0] sizes[5][3];
    obs_size = '{3{SizeWidth'(ONE)}};
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed queries
    pending_q.push_back('0);
    pending_q.push_back({{3{32'sd0}}, {3{32'sd65536}}, {3{32'sd0}}, {3{32'sd0}}});
    pending_q.push_back({-32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536,
                         32'sd131072, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0});
    pending_q.push_back({32'sd0, -32'sd65536, 32'sd0, 32'sd65536, 32'sd0, 32'sd65536,
                         32'sd0, 32'sd131072, 32'sd0, 32'sd0, 32'sd65536, 32'sd0});
    pending_q.push_back({32'sd0, 32'sd0, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd0,
                         32'sd0, 32'sd0, 32'sd131072, 32'sd0, 32'sd0, 32'sd65536});
    pending_q.push_back({{3{-32'sd65536}}, {3{32'sd0}}, {3{32'sd131072}},
                         {3{32'sd65536}}});
    pending_q.push_back({32'sd196608, 32'sd0, 32'sd0, 32'sd262144, 32'sd65536,
                         32'sd65536, -32'sd131072, 32'sd0, 32'sd0, 32'sd65536,
                         32'sd0, 32'sd0});
    pending_q.push_back({-32'sd655360, 32'sd0, 32'sd0, -32'sd589824, 32'sd65536,
                         32'sd65536, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    pending_q.push_back({{6{SMIN}}, {3{32'sd1}}, {3{SMAX}}});
    pending_q.push_back({{6{SMAX}}, {3{-32'sd1}}, {3{SMIN}}});
    pending_q.push_back({{3{SMIN}}, {3{SMAX}}, {3{SMIN}}, {3{SMAX}}});
    pending_q.push_back({{3{SMAX}}, {3{SMIN}}, {3{SMAX}}, {3{SMIN}}});
    pending_q.push_back({{6{32'sd0}}, {3{SMIN}}, {3{32'sd0}}});
    pending_q.push_back({{6{32'sd0}}, {3{SMAX}}, {3{32'sd0}}});
    pending_q.push_back({{3{32'hffffffff}}, {3{32'h55555555}}, {3{32'haaaaaaaa}},
                         {3{32'h0f0f0f0f}}});
    drain();

    sizes = '{'{31'd0, 31'd0, 31'd0}, '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff},
              '{31'd65536, 31'd131072, 31'd32768}, '{31'd0, 31'h7fffffff, 31'd65536},
              '{31'd0, 31'd0, 31'd0}};
    for (int p = 0; p < 5; p++) begin
      if (p == 4)
        for (int i = 0; i < 3; i++)
          sizes[p][i] = SizeWidth'($urandom_range(0, 3 * 65536));
      write_size(CFG_SIZE_X, sizes[p][0]);
      write_size(CFG_SIZE_Y, sizes[p][1]);
      write_size(CFG_SIZE_Z, sizes[p][2]);
      for (int n = 0; n < 350; n++) pending_q.push_back(rand_query());
      drain();
    end

    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
